// ----- design/dbq_pkg.sv -----
// Shared types and constants for the bounded deque block.
// Holds opcode and status codes and the controller-to-datapath command and status structs.
// No dependencies.
`default_nettype none

package dbq_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 6;

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_READ_FRONT = 3'd2,
    OP_READ_BACK  = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_POP_BACK   = 3'd5,
    OP_DELETE     = 3'd6,
    OP_COUNT      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Read address source for the element store.
  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_HEAD   = 3'd1,
    RD_TAIL   = 3'd2,
    RD_SECOND = 3'd3,
    RD_NEXT   = 3'd4,
    RD_PREV   = 3'd5
  } rd_sel_t;

  // Update of head and occupancy; pushes also write the store.
  typedef enum logic [2:0] {
    UPD_NONE       = 3'd0,
    UPD_PUSH_FRONT = 3'd1,
    UPD_PUSH_BACK  = 3'd2,
    UPD_POP_FRONT  = 3'd3,
    UPD_POP_BACK   = 3'd4
  } upd_t;

  typedef enum logic [1:0] {
    D_ZERO  = 2'd0,
    D_RAM   = 2'd1,
    D_VALUE = 2'd2
  } dsel_t;

  typedef struct packed {
    logic    latch;          // capture the input value
    rd_sel_t rd;
    upd_t    upd;
    logic    shift;          // write read data one slot toward the front
    logic    mark;           // remember the address of the matched entry
    logic    emit;           // load the result registers
    dsel_t   dsel;
    status_t status;
    logic    last_from_idx;  // last flag follows the read index
  } dbq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic few;       // fewer than three elements: no interior entries
    logic match;     // read data equals the latched value
    logic idx_last;  // read data is the back element position
    logic idx_pen;   // read data is the last interior position
  } dbq_sts_t;

endpackage

`default_nettype wire

// ----- design/dbq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; sized by WIDTH and DEPTH.
`default_nettype none

module dbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/dbq_ctrl.sv -----
// Controller state machine for the bounded deque: sequences each beat's store accesses.
// Depends on dbq_pkg for opcodes, status codes and the command/status structs.
`default_nettype none

module dbq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [2:0]       opcode,
  input  wire dbq_pkg::dbq_sts_t sts,
  output dbq_pkg::dbq_cmd_t     cmd,
  output logic                  busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_STREAM,
    S_POP,
    S_DEL_HEAD,
    S_DEL_TAIL,
    S_DEL_SCAN,
    S_DEL_SHIFT
  } state_t;

  state_t        state;
  state_t        state_next;
  dbq_pkg::op_t  op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (cmd.latch) begin
      op <= dbq_pkg::op_t'(opcode);
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.latch = start;
        if (start) begin
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_next = S_IDLE;
        priority if (op == dbq_pkg::OP_PUSH_FRONT || op == dbq_pkg::OP_PUSH_BACK) begin
          cmd.emit = 1'b1;
          if (sts.full) begin
            cmd.status = dbq_pkg::ST_FULL;
          end else begin
            cmd.status = dbq_pkg::ST_OK;
            if (op == dbq_pkg::OP_PUSH_FRONT) begin
              cmd.upd = dbq_pkg::UPD_PUSH_FRONT;
            end else begin
              cmd.upd = dbq_pkg::UPD_PUSH_BACK;
            end
          end
        end else if (op == dbq_pkg::OP_COUNT) begin
          cmd.emit = 1'b1;
          if (sts.empty) begin
            cmd.status = dbq_pkg::ST_EMPTY;
          end else begin
            cmd.status = dbq_pkg::ST_OK;
          end
        end else if (sts.empty) begin
          cmd.emit   = 1'b1;
          cmd.status = dbq_pkg::ST_EMPTY;
        end else if (op == dbq_pkg::OP_READ_FRONT) begin
          cmd.rd     = dbq_pkg::RD_HEAD;
          state_next = S_STREAM;
        end else if (op == dbq_pkg::OP_READ_BACK) begin
          cmd.rd     = dbq_pkg::RD_TAIL;
          state_next = S_STREAM;
        end else if (op == dbq_pkg::OP_POP_FRONT) begin
          cmd.rd     = dbq_pkg::RD_HEAD;
          state_next = S_POP;
        end else if (op == dbq_pkg::OP_POP_BACK) begin
          cmd.rd     = dbq_pkg::RD_TAIL;
          state_next = S_POP;
        end else begin
          cmd.rd     = dbq_pkg::RD_HEAD;
          state_next = S_DEL_HEAD;
        end
      end

      S_STREAM: begin
        if (op == dbq_pkg::OP_READ_BACK) begin
          cmd.rd = dbq_pkg::RD_PREV;
        end else begin
          cmd.rd = dbq_pkg::RD_NEXT;
        end
        cmd.emit          = 1'b1;
        cmd.dsel          = dbq_pkg::D_RAM;
        cmd.status        = dbq_pkg::ST_OK;
        cmd.last_from_idx = 1'b1;
        if (sts.idx_last) begin
          state_next = S_IDLE;
        end
      end

      S_POP: begin
        cmd.emit   = 1'b1;
        cmd.dsel   = dbq_pkg::D_RAM;
        cmd.status = dbq_pkg::ST_OK;
        if (op == dbq_pkg::OP_POP_FRONT) begin
          cmd.upd = dbq_pkg::UPD_POP_FRONT;
        end else begin
          cmd.upd = dbq_pkg::UPD_POP_BACK;
        end
        state_next = S_IDLE;
      end

      S_DEL_HEAD: begin
        cmd.rd = dbq_pkg::RD_TAIL;
        if (sts.match) begin
          cmd.upd    = dbq_pkg::UPD_POP_FRONT;
          cmd.emit   = 1'b1;
          cmd.dsel   = dbq_pkg::D_VALUE;
          cmd.status = dbq_pkg::ST_OK;
          state_next = S_IDLE;
        end else begin
          state_next = S_DEL_TAIL;
        end
      end

      S_DEL_TAIL: begin
        cmd.rd = dbq_pkg::RD_SECOND;
        if (sts.match) begin
          cmd.upd    = dbq_pkg::UPD_POP_BACK;
          cmd.emit   = 1'b1;
          cmd.dsel   = dbq_pkg::D_VALUE;
          cmd.status = dbq_pkg::ST_OK;
          state_next = S_IDLE;
        end else if (sts.few) begin
          cmd.emit   = 1'b1;
          cmd.status = dbq_pkg::ST_NOTFOUND;
          state_next = S_IDLE;
        end else begin
          state_next = S_DEL_SCAN;
        end
      end

      S_DEL_SCAN: begin
        cmd.rd = dbq_pkg::RD_NEXT;
        if (sts.match) begin
          cmd.mark   = 1'b1;
          state_next = S_DEL_SHIFT;
        end else if (sts.idx_pen) begin
          cmd.emit   = 1'b1;
          cmd.status = dbq_pkg::ST_NOTFOUND;
          state_next = S_IDLE;
        end
      end

      S_DEL_SHIFT: begin
        cmd.rd    = dbq_pkg::RD_NEXT;
        cmd.shift = 1'b1;
        if (sts.idx_last) begin
          cmd.upd    = dbq_pkg::UPD_POP_BACK;
          cmd.emit   = 1'b1;
          cmd.dsel   = dbq_pkg::D_VALUE;
          cmd.status = dbq_pkg::ST_OK;
          state_next = S_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/dbq_datapath.sv -----
// Datapath of the bounded deque: head and occupancy, store addressing and result registers.
// Depends on dbq_pkg and instantiates dbq_ram for the element store.
`default_nettype none

module dbq_datapath #(
  parameter int DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dbq_pkg::dbq_cmd_t cmd,
  input  wire dbq_pkg::data_t    value,
  output dbq_pkg::dbq_sts_t      sts,
  output logic                   done,
  output dbq_pkg::data_t         data,
  output dbq_pkg::count_t        count,
  output logic [1:0]             status,
  output logic                   last
);

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic [AW-1:0]  head;
  logic [AW-1:0]  head_next;
  logic [OW-1:0]  occ;
  logic [OW-1:0]  occ_next;
  logic [OW-1:0]  occ_m1;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  last_addr;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  tail_slot;
  logic [AW-1:0]  back_slot;
  logic [SW-1:0]  tail_sum;
  logic [SW-1:0]  back_sum;
  logic           we;
  dbq_pkg::data_t val;
  dbq_pkg::data_t wdata;
  dbq_pkg::data_t rdata;

  function automatic logic [AW-1:0] inc_addr(input logic [AW-1:0] a);
    if (a == AW'(DEPTH - 1)) begin
      return '0;
    end
    return a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec_addr(input logic [AW-1:0] a);
    if (a == '0) begin
      return AW'(DEPTH - 1);
    end
    return a - 1'b1;
  endfunction

  assign occ_m1 = occ - 1'b1;

  // Slot of the back element and of the first free slot behind it, modulo DEPTH.
  always_comb begin
    tail_sum  = {1'b0, head} + SW'(occ_m1);
    back_sum  = {1'b0, head} + SW'(occ);
    tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  end

  always_comb begin
    unique case (cmd.rd)
      dbq_pkg::RD_HEAD:   raddr = head;
      dbq_pkg::RD_TAIL:   raddr = tail_slot;
      dbq_pkg::RD_SECOND: raddr = inc_addr(head);
      dbq_pkg::RD_NEXT:   raddr = inc_addr(last_addr);
      dbq_pkg::RD_PREV:   raddr = dec_addr(last_addr);
      default:            raddr = last_addr;
    endcase
  end

  always_comb begin
    head_next = head;
    occ_next  = occ;
    unique case (cmd.upd)
      dbq_pkg::UPD_PUSH_FRONT: begin
        head_next = dec_addr(head);
        occ_next  = occ + 1'b1;
      end
      dbq_pkg::UPD_PUSH_BACK: begin
        occ_next = occ + 1'b1;
      end
      dbq_pkg::UPD_POP_FRONT: begin
        head_next = inc_addr(head);
        occ_next  = occ_m1;
      end
      dbq_pkg::UPD_POP_BACK: begin
        occ_next = occ_m1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    we    = cmd.shift || cmd.upd == dbq_pkg::UPD_PUSH_FRONT ||
            cmd.upd == dbq_pkg::UPD_PUSH_BACK;
    wdata = cmd.shift ? rdata : val;
    priority if (cmd.upd == dbq_pkg::UPD_PUSH_FRONT) begin
      waddr = dec_addr(head);
    end else if (cmd.upd == dbq_pkg::UPD_PUSH_BACK) begin
      waddr = back_slot;
    end else begin
      waddr = wr_addr;
    end
  end

  dbq_ram #(
    .WIDTH (dbq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.full     = (occ == OW'(DEPTH));
    sts.empty    = (occ == '0);
    sts.few      = (occ < OW'(3));
    sts.match    = (rdata == val);
    sts.idx_last = (OW'(idx) == occ_m1);
    sts.idx_pen  = (OW'(idx) == occ - OW'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
      done <= 1'b0;
    end else begin
      head <= head_next;
      occ  <= occ_next;
      done <= cmd.emit;
    end

    if (cmd.latch) begin
      val <= value;
    end

    last_addr <= raddr;
    unique case (cmd.rd)
      dbq_pkg::RD_HEAD, dbq_pkg::RD_TAIL: idx <= '0;
      dbq_pkg::RD_SECOND:                 idx <= AW'(1);
      dbq_pkg::RD_NEXT, dbq_pkg::RD_PREV: idx <= idx + 1'b1;
      default:                            idx <= idx;
    endcase

    if (cmd.mark || cmd.shift) begin
      wr_addr <= last_addr;
    end

    if (cmd.emit) begin
      unique case (cmd.dsel)
        dbq_pkg::D_RAM:   data <= rdata;
        dbq_pkg::D_VALUE: data <= val;
        default:          data <= '0;
      endcase
      count  <= dbq_pkg::count_t'(occ_next);
      status <= cmd.status;
      last   <= cmd.last_from_idx ? sts.idx_last : 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/bounded_deque_with_value_delete.sv -----
// Top level of the bounded double-ended queue with delete by value.
// Depends on dbq_pkg; instantiates dbq_ctrl (sequencer) and dbq_datapath (store and registers).
`default_nettype none

// Bounded deque of signed 32-bit values, up to DEPTH entries, held front to
// back in a circular store. A command beat is taken on a rising edge with start
// high and busy low; busy then stays high until the beat's last result is
// loaded. Every result shows on data/count/status/last for exactly one cycle
// with done high, and the receiver cannot hold it off. With n the number of
// elements held: push, count, and any command on an empty store load their
// result in the dispatch state; pop reads its entry there and loads it in the
// pop state. A read-out gives n results, one per cycle, from the stream state.
// Delete by value reads the front, then the back, then walks the interior one
// entry per cycle, and on a hit closes the gap one entry per cycle from the
// matched entry on, so walk and gap closing together pass each interior entry
// once. The single read port and single write port of the element store set
// this pace. The store comes up undefined and no data read from outside the
// held range is ever used, so no clearing pass runs after reset. With
// DEPTH = 64 a full store reports count 0.
module bounded_deque_with_value_delete #(
  parameter int DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         opcode,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic signed [31:0]      data,
  output logic [5:0]              count,
  output logic [1:0]              status,
  output logic                    last
);

  dbq_pkg::dbq_cmd_t cmd;
  dbq_pkg::dbq_sts_t sts;
  dbq_pkg::data_t    data_q;

  // Sequence each beat: dispatch, then, where needed, stream, pop, or the delete walk.
  dbq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold head, occupancy and the store; register every result.
  dbq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .value  (dbq_pkg::data_t'(value)),
    .sts    (sts),
    .done   (done),
    .data   (data_q),
    .count  (count),
    .status (status),
    .last   (last)
  );

  assign data = signed'(data_q);

endmodule

`default_nettype wire

// ----- tb/bounded_deque_with_value_delete_tb.sv -----
// Self-checking testbench for the bounded deque with delete by value.
// Depends on dbq_pkg and bounded_deque_with_value_delete; drives command beats, predicts
// every result beat from a queue model of the held values and checks each one on arrival.
`timescale 1ns / 100ps

module bounded_deque_with_value_delete_tb;

  localparam int DEPTH = 32;
  localparam int RANDOM_ITEMS = 86;
  localparam int TAIL_CYCLES = 80;     // longer than a delete walk over a full store
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    dbq_pkg::data_t   data;
    dbq_pkg::count_t  count;
    dbq_pkg::status_t status;
    logic             last;
  } deque_beat_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         opcode;
  logic signed [31:0] value;
  logic               done;
  logic signed [31:0] data;
  logic [5:0]         count;
  logic [1:0]         status;
  logic               last;

  // Values held by the deque, front first, and result beats still to arrive.
  dbq_pkg::data_t held_values[$];
  deque_beat_t    pending_beats[$];

  int mismatches = 0;
  int commands_sent = 0;
  int beats_checked = 0;
  int full_rejects = 0;
  int delete_misses = 0;
  int burst_left = 0;
  int quiet_bursts = 0;

  bounded_deque_with_value_delete #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .value(value),
    .done(done), .data(data), .count(count), .status(status), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit: far beyond the slowest legal run (every item a full walk plus the longest gap).
  initial begin
    #2_000_000;
    $display("bounded_deque_with_value_delete test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Queue one expected result beat; count reflects the deque after the command.
  task automatic queue_beat(input dbq_pkg::data_t d, input dbq_pkg::status_t st,
                            input logic lst);
    deque_beat_t b;
    b.data = d;
    b.count = dbq_pkg::count_t'(held_values.size());
    b.status = st;
    b.last = lst;
    pending_beats.push_back(b);
  endtask

  // Apply one accepted command to the model and queue the beats it must produce.
  task automatic predict_command(input dbq_pkg::op_t op, input dbq_pkg::data_t val);
    int n;
    int i;
    int hit;
    dbq_pkg::data_t d;
    n = held_values.size();
    unique case (op)
      dbq_pkg::OP_PUSH_FRONT, dbq_pkg::OP_PUSH_BACK: begin
        if (n >= DEPTH) begin
          full_rejects++;
          queue_beat('0, dbq_pkg::ST_FULL, 1'b1);
        end else begin
          if (op == dbq_pkg::OP_PUSH_FRONT) held_values.push_front(val);
          else held_values.push_back(val);
          queue_beat('0, dbq_pkg::ST_OK, 1'b1);
        end
      end
      dbq_pkg::OP_READ_FRONT, dbq_pkg::OP_READ_BACK: begin
        if (n == 0) begin
          queue_beat('0, dbq_pkg::ST_EMPTY, 1'b1);
        end else begin
          // One beat per element, last flagged on the final one.
          for (i = 0; i < n; i++) begin
            d = (op == dbq_pkg::OP_READ_FRONT) ? held_values[i] : held_values[n - 1 - i];
            queue_beat(d, dbq_pkg::ST_OK, (i == n - 1));
          end
        end
      end
      dbq_pkg::OP_POP_FRONT, dbq_pkg::OP_POP_BACK: begin
        if (n == 0) begin
          queue_beat('0, dbq_pkg::ST_EMPTY, 1'b1);
        end else begin
          d = (op == dbq_pkg::OP_POP_FRONT) ? held_values.pop_front()
                                            : held_values.pop_back();
          queue_beat(d, dbq_pkg::ST_OK, 1'b1);
        end
      end
      dbq_pkg::OP_DELETE: begin
        if (n == 0) begin
          queue_beat('0, dbq_pkg::ST_EMPTY, 1'b1);
        end else if (held_values[0] == val) begin
          void'(held_values.pop_front());
          queue_beat(val, dbq_pkg::ST_OK, 1'b1);
        end else if (held_values[n - 1] == val) begin
          // A matching back element wins over any interior match.
          void'(held_values.pop_back());
          queue_beat(val, dbq_pkg::ST_OK, 1'b1);
        end else begin
          hit = -1;
          for (i = 1; i < n - 1; i++) begin
            if (hit < 0 && held_values[i] == val) hit = i;
          end
          if (hit < 0) begin
            delete_misses++;
            queue_beat('0, dbq_pkg::ST_NOTFOUND, 1'b1);
          end else begin
            held_values.delete(hit);
            queue_beat(val, dbq_pkg::ST_OK, 1'b1);
          end
        end
      end
      default: queue_beat('0, (n == 0) ? dbq_pkg::ST_EMPTY : dbq_pkg::ST_OK, 1'b1);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Send one command beat. Bursts of random length are separated by random gaps,
  // with runs of bursts that carry no gap at all. Start stays high across a burst.
  task automatic send_beat(input dbq_pkg::op_t op, input dbq_pkg::data_t val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (quiet_bursts > 0) begin
        quiet_bursts--;
        gap = 0;
      end else begin
        case ($urandom_range(0, 9))
          0:       begin quiet_bursts = $urandom_range(2, 6); gap = 0; end
          1, 2:    gap = 0;
          3:       gap = $urandom_range(10, 40);   // long gaps, the longest spanning a full walk
          default: gap = $urandom_range(1, 6);
        endcase
      end
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    opcode <= op;
    value <= val;
    // The beat is taken at the first rising edge that sees busy low.
    @(posedge clk);
    while (busy) @(posedge clk);
    commands_sent++;
    predict_command(op, val);
  endtask

  // Value for a push: extremes, a narrow band that breeds duplicates, held values, or anything.
  function automatic dbq_pkg::data_t pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return dbq_pkg::data_t'($urandom_range(0, 6)) - 32'd3;
      4, 5: begin
        if (held_values.size() > 0)
          return held_values[$urandom_range(0, held_values.size() - 1)];
        return dbq_pkg::data_t'($urandom);
      end
      default: return dbq_pkg::data_t'($urandom);
    endcase
  endfunction

  // Delete mostly hits a held value so the walk and gap closing get exercised.
  function automatic dbq_pkg::data_t delete_value();
    if (held_values.size() > 0 && $urandom_range(0, 9) < 7)
      return held_values[$urandom_range(0, held_values.size() - 1)];
    return pick_value();
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Compare every result beat with the oldest expectation; the receiver never stalls.
  always @(posedge clk) begin
    deque_beat_t got;
    deque_beat_t want;
    if (!rst && done) begin
      got.data = data;
      got.count = count;
      got.status = dbq_pkg::status_t'(status);
      got.last = last;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result beat data=%h count=%0d status=%0d last=%0b",
                   $realtime, got.data, got.count, got.status, got.last);
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (got != want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: result mismatch: expected data=%h count=%0d status=%0d last=%0b,",
                      " got data=%h count=%0d status=%0d last=%0b"},
                     $realtime, want.data, want.count, want.status, want.last,
                     got.data, got.count, got.status, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every command on an empty store reports empty, except push.
  task automatic test_empty_store();
    send_beat(dbq_pkg::OP_POP_FRONT, 32'h0);
    send_beat(dbq_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
    send_beat(dbq_pkg::OP_READ_FRONT, 32'h0);
    send_beat(dbq_pkg::OP_READ_BACK, 32'h0);
    send_beat(dbq_pkg::OP_DELETE, 32'h0);
    send_beat(dbq_pkg::OP_COUNT, 32'h0);
  endtask

  // Push the value extremes at both ends, read them out both ways and pop one from each end.
  task automatic test_value_extremes();
    send_beat(dbq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_beat(dbq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send_beat(dbq_pkg::OP_PUSH_BACK, 32'h0000_0000);
    send_beat(dbq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_beat(dbq_pkg::OP_READ_FRONT, 32'h0);
    send_beat(dbq_pkg::OP_READ_BACK, 32'h0);
    send_beat(dbq_pkg::OP_COUNT, 32'h0);
    send_beat(dbq_pkg::OP_POP_FRONT, 32'h0);
    send_beat(dbq_pkg::OP_POP_BACK, 32'h0);
  endtask

  // Delete order: front, then back, then first interior match; a miss leaves all in place.
  task automatic test_delete_order();
    send_beat(dbq_pkg::OP_PUSH_BACK, 32'd5);
    send_beat(dbq_pkg::OP_PUSH_BACK, 32'd9);
    send_beat(dbq_pkg::OP_PUSH_BACK, 32'd5);
    send_beat(dbq_pkg::OP_DELETE, 32'd5);            // back wins over the interior 5
    send_beat(dbq_pkg::OP_DELETE, 32'h8000_0000);    // front
    send_beat(dbq_pkg::OP_DELETE, 32'd5);            // interior, gap closes
    send_beat(dbq_pkg::OP_DELETE, 32'd1234);         // absent
    send_beat(dbq_pkg::OP_DELETE, 32'd9);            // back
    send_beat(dbq_pkg::OP_DELETE, 32'h7FFF_FFFF);    // last element
  endtask

  // Fill the store, hit it when full, walk it both ways, then drain part of it.
  task automatic test_full_store();
    while (held_values.size() < DEPTH)
      send_beat($urandom_range(0, 1) ? dbq_pkg::OP_PUSH_FRONT : dbq_pkg::OP_PUSH_BACK,
                pick_value());
    send_beat(dbq_pkg::OP_PUSH_FRONT, dbq_pkg::data_t'($urandom));
    send_beat(dbq_pkg::OP_PUSH_BACK, dbq_pkg::data_t'($urandom));
    send_beat(dbq_pkg::OP_COUNT, 32'h0);
    send_beat(dbq_pkg::OP_READ_FRONT, 32'h0);
    send_beat(dbq_pkg::OP_READ_BACK, 32'h0);
    send_beat(dbq_pkg::OP_DELETE, held_values[DEPTH / 2]);
    repeat (12)
      send_beat($urandom_range(0, 1) ? dbq_pkg::OP_POP_FRONT : dbq_pkg::OP_POP_BACK, 32'h0);
  endtask

  // Random traffic in spells that grow, shrink or hover, so the fill level sweeps its range.
  task automatic test_random_traffic(input int n_items);
    int i;
    int push_pct;
    dbq_pkg::op_t op;
    dbq_pkg::data_t val;
    push_pct = 50;
    for (i = 0; i < n_items; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 75;
          1:       push_pct = 20;
          default: push_pct = 45;
        endcase
      end
      if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? dbq_pkg::OP_PUSH_FRONT : dbq_pkg::OP_PUSH_BACK;
      end else begin
        case ($urandom_range(0, 9))
          0:       op = dbq_pkg::OP_READ_FRONT;
          1:       op = dbq_pkg::OP_READ_BACK;
          2, 3:    op = dbq_pkg::OP_POP_FRONT;
          4, 5:    op = dbq_pkg::OP_POP_BACK;
          6, 7, 8: op = dbq_pkg::OP_DELETE;
          default: op = dbq_pkg::OP_COUNT;
        endcase
      end
      case (op)
        dbq_pkg::OP_DELETE:                            val = delete_value();
        dbq_pkg::OP_PUSH_FRONT, dbq_pkg::OP_PUSH_BACK: val = pick_value();
        default: val = dbq_pkg::data_t'($urandom);   // ignored, but toggle it
      endcase
      send_beat(op, val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    start = 1'b0;
    opcode = '0;
    value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_value_extremes();
    test_delete_order();
    test_full_store();
    test_random_traffic(RANDOM_ITEMS);

    @(negedge clk);
    start <= 1'b0;

    // Drain: wait for every expected beat, then watch for stray ones.
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d commands and checked %0d result beats (%0d mismatches).",
             commands_sent, beats_checked, mismatches);
    $display("Pushes into a full store: %0d; deletes of absent values: %0d.",
             full_rejects, delete_misses);
    if (mismatches == 0) begin
      $display("bounded_deque_with_value_delete test passed");
    end else begin
      $display("bounded_deque_with_value_delete test failed");
    end
    $finish;
  end

endmodule
